>>> hdl/s2a_pkg.sv
// Shared types, constants and key translation tables for the scancode-to-ASCII FIFO.
package s2a_pkg;

   localparam int BUF_DEPTH_DEF = 16;
   localparam int SCAN_W        = 8;
   localparam int CHAR_W        = 7;

   localparam logic [SCAN_W-1:0] KEY_LSHIFT     = 8'd42;
   localparam logic [SCAN_W-1:0] KEY_RSHIFT     = 8'd54;
   localparam logic [SCAN_W-1:0] KEY_LSHIFT_BRK = 8'd170;
   localparam logic [SCAN_W-1:0] KEY_RSHIFT_BRK = 8'd182;
   localparam logic [SCAN_W-1:0] KEY_CAPS       = 8'd58;
   localparam logic [SCAN_W-1:0] KEY_CTRL       = 8'd29;
   localparam logic [SCAN_W-1:0] KEY_ALT        = 8'd56;

   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic              rd;
      logic              push;
      logic [CHAR_W-1:0] ch;
   } ring_ctl_type;

   function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         7'd1:  c = 7'd27;
         7'd2:  c = 7'h31;
         7'd3:  c = 7'h32;
         7'd4:  c = 7'h33;
         7'd5:  c = 7'h34;
         7'd6:  c = 7'h35;
         7'd7:  c = 7'h36;
         7'd8:  c = 7'h37;
         7'd9:  c = 7'h38;
         7'd10: c = 7'h39;
         7'd11: c = 7'h30;
         7'd12: c = 7'h2d;
         7'd13: c = 7'h3d;
         7'd14: c = 7'd8;
         7'd15: c = 7'd9;
         7'd16: c = 7'h71;
         7'd17: c = 7'h77;
         7'd18: c = 7'h65;
         7'd19: c = 7'h72;
         7'd20: c = 7'h74;
         7'd21: c = 7'h79;
         7'd22: c = 7'h75;
         7'd23: c = 7'h69;
         7'd24: c = 7'h6f;
         7'd25: c = 7'h70;
         7'd26: c = 7'h5b;
         7'd27: c = 7'h5d;
         7'd28: c = 7'd10;
         7'd30: c = 7'h61;
         7'd31: c = 7'h73;
         7'd32: c = 7'h64;
         7'd33: c = 7'h66;
         7'd34: c = 7'h67;
         7'd35: c = 7'h68;
         7'd36: c = 7'h6a;
         7'd37: c = 7'h6b;
         7'd38: c = 7'h6c;
         7'd39: c = 7'h3b;
         7'd40: c = 7'd39;
         7'd41: c = 7'h60;
         7'd43: c = 7'd92;
         7'd44: c = 7'h7a;
         7'd45: c = 7'h78;
         7'd46: c = 7'h63;
         7'd47: c = 7'h76;
         7'd48: c = 7'h62;
         7'd49: c = 7'h6e;
         7'd50: c = 7'h6d;
         7'd51: c = 7'h2c;
         7'd52: c = 7'h2e;
         7'd53: c = 7'h2f;
         7'd55: c = 7'h2a;
         7'd57: c = 7'h20;
         7'd72: c = 7'd15;
         7'd74: c = 7'h2d;
         7'd75: c = 7'd13;
         7'd77: c = 7'd12;
         7'd78: c = 7'h2b;
         7'd80: c = 7'd14;
         7'd81: c = 7'd14;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] idx);
      logic [CHAR_W-1:0] c;
      case (idx)
         7'd1:  c = 7'd27;
         7'd2:  c = 7'h21;
         7'd3:  c = 7'h40;
         7'd4:  c = 7'h23;
         7'd5:  c = 7'h24;
         7'd6:  c = 7'h25;
         7'd7:  c = 7'h5e;
         7'd8:  c = 7'h26;
         7'd9:  c = 7'h2a;
         7'd10: c = 7'h28;
         7'd11: c = 7'h29;
         7'd12: c = 7'h5f;
         7'd13: c = 7'h2b;
         7'd14: c = 7'd8;
         7'd15: c = 7'd9;
         7'd16: c = 7'h51;
         7'd17: c = 7'h57;
         7'd18: c = 7'h45;
         7'd19: c = 7'h52;
         7'd20: c = 7'h54;
         7'd21: c = 7'h59;
         7'd22: c = 7'h55;
         7'd23: c = 7'h49;
         7'd24: c = 7'h4f;
         7'd25: c = 7'h50;
         7'd26: c = 7'h7b;
         7'd27: c = 7'h7d;
         7'd28: c = 7'd10;
         7'd30: c = 7'h41;
         7'd31: c = 7'h53;
         7'd32: c = 7'h44;
         7'd33: c = 7'h46;
         7'd34: c = 7'h47;
         7'd35: c = 7'h48;
         7'd36: c = 7'h4a;
         7'd37: c = 7'h4b;
         7'd38: c = 7'h4c;
         7'd39: c = 7'h3a;
         7'd40: c = 7'd34;
         7'd41: c = 7'h7e;
         7'd43: c = 7'h7c;
         7'd44: c = 7'h5a;
         7'd45: c = 7'h58;
         7'd46: c = 7'h43;
         7'd47: c = 7'h56;
         7'd48: c = 7'h42;
         7'd49: c = 7'h4e;
         7'd50: c = 7'h4d;
         7'd51: c = 7'h3c;
         7'd52: c = 7'h3e;
         7'd53: c = 7'h3f;
         7'd55: c = 7'h2a;
         7'd57: c = 7'h20;
         7'd72: c = 7'd15;
         7'd74: c = 7'h2d;
         7'd75: c = 7'd13;
         7'd77: c = 7'd12;
         7'd78: c = 7'h2b;
         7'd80: c = 7'd14;
         7'd81: c = 7'd14;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/s2a_channels.sv
// Valid/ready channel interfaces for the request and response sides.
interface s2a_req_if;
   import s2a_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [SCAN_W-1:0] scan_code;

   modport source (output valid, output cmd, output scan_code, input ready);
   modport sink   (input valid, input cmd, input scan_code, output ready);
endinterface

interface s2a_rsp_if;
   import s2a_pkg::*;
   logic              valid;
   logic              ready;
   logic              buffer_empty;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output buffer_empty, output char_code, input ready);
   modport sink   (input valid, input buffer_empty, input char_code, output ready);
endinterface

>>> hdl/s2a_xlate.sv
// Modifier tracking and scancode-to-character translation.
module s2a_xlate (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      ev,
   input  logic [s2a_pkg::SCAN_W-1:0] code,
   output logic                      push,
   output logic [s2a_pkg::CHAR_W-1:0] ch
);
   import s2a_pkg::*;

   logic              shift_ff, shift_in;
   logic              caps_ff, caps_in;
   logic [CHAR_W-1:0] base;
   logic              letter;
   logic              use_shift;

   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      push     = 1'b0;
      if (ev) begin
         if (code[SCAN_W-1]) begin
            if (code == KEY_LSHIFT_BRK || code == KEY_RSHIFT_BRK) begin
               shift_in = 1'b0;
            end
         end else if (code == KEY_CAPS) begin
            caps_in = ~caps_ff;
         end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_in = 1'b1;
         end else if (code != KEY_CTRL && code != KEY_ALT) begin
            push = 1'b1;
         end
      end
   end

   assign base      = plain_char(code[6:0]);
   assign letter    = (base >= 7'h61) && (base <= 7'h7a);
   assign use_shift = letter ? (shift_ff ^ caps_ff) : shift_ff;
   assign ch        = use_shift ? shift_char(code[6:0]) : base;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
      end
   end

endmodule

>>> hdl/s2a_ring.sv
// Character ring buffer with overwrite on full and a registered read port.
module s2a_ring #(
   parameter int BUF_DEPTH = s2a_pkg::BUF_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  s2a_pkg::ring_ctl_type      ctl,
   input  logic                       out_ready,
   output logic                       out_valid,
   output logic                       out_empty,
   output logic [s2a_pkg::CHAR_W-1:0] out_char
);
   import s2a_pkg::*;

   localparam int PTR_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int FILL_W = $clog2(BUF_DEPTH + 1);

   logic [CHAR_W-1:0] char_store_ff [BUF_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              valid_ff, valid_in;
   logic              empty_ff, empty_in;
   logic              is_empty;
   logic              is_full;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign is_empty = (fill_ff == '0);
   assign is_full  = (fill_ff == FILL_W'(BUF_DEPTH));

   always_comb begin
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      fill_in   = fill_ff;
      empty_in  = empty_ff;
      valid_in  = valid_ff && !out_ready;
      if (ctl.push) begin
         wr_pos_in = next_pos(wr_pos_ff);
         if (is_full) begin
            rd_pos_in = next_pos(rd_pos_ff);
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end else if (ctl.rd) begin
         valid_in = 1'b1;
         empty_in = is_empty;
         if (!is_empty) begin
            rd_pos_in = next_pos(rd_pos_ff);
            fill_in   = fill_ff - FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         fill_ff   <= '0;
         valid_ff  <= 1'b0;
         empty_ff  <= 1'b1;
      end else begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         fill_ff   <= fill_in;
         valid_ff  <= valid_in;
         empty_ff  <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         char_store_ff[wr_pos_ff] <= ctl.ch;
      end
      if (ctl.rd && !is_empty) begin
         rd_data_ff <= char_store_ff[rd_pos_ff];
      end
   end

   assign out_valid = valid_ff;
   assign out_empty = empty_ff;
   assign out_char  = empty_ff ? '0 : rd_data_ff;

endmodule

>>> hdl/scancode_to_ascii_fifo.sv
// Top level of the set-1 scancode to ASCII translator with an overwriting character FIFO.
// A new request is taken in each cycle in which the response register is empty or its
// transfer completes. Scancode requests update the shift and caps lock state or push one
// character into a ring of BUF_DEPTH entries, overwriting the oldest entry when the ring
// is full; they produce no response. A read request produces one response in the cycle
// after its transfer, set by the registered read port of the character memory: the
// oldest character, or buffer_empty with a zero character.
module scancode_to_ascii_fifo #(
   parameter int BUF_DEPTH = s2a_pkg::BUF_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   s2a_req_if.sink         req_chan,
   s2a_rsp_if.source       rsp_chan
);
   import s2a_pkg::*;

   logic              accept;
   logic              push;
   logic [CHAR_W-1:0] ch;
   ring_ctl_type      ctl;

   assign req_chan.ready = !rsp_chan.valid || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   s2a_xlate u_xlate (
      .clock (clock),
      .reset (reset),
      .ev    (accept && (req_chan.cmd == CMD_SCAN)),
      .code  (req_chan.scan_code),
      .push  (push),
      .ch    (ch)
   );

   always_comb begin
      ctl.rd   = accept && (req_chan.cmd == CMD_READ);
      ctl.push = push;
      ctl.ch   = ch;
   end

   s2a_ring #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_empty (rsp_chan.buffer_empty),
      .out_char  (rsp_chan.char_code)
   );

endmodule

>>> test/scancode_to_ascii_fifo_test.sv
// Self-checking testbench for the scancode to ASCII translator and its overwriting character FIFO.
`timescale 1ns / 100ps

module scancode_to_ascii_fifo_test;
   import s2a_pkg::*;

   localparam int                RING_DEPTH   = BUF_DEPTH_DEF;
   localparam logic [SCAN_W-1:0] BREAK_BIT    = 8'h80;
   localparam int                QUIET_LIMIT  = 2000;
   localparam int                DRAIN_CYCLES = 8;
   localparam int                MAX_REPORTS  = 10;
   localparam int                LONG_HOLD    = 150;

   typedef struct packed {
      logic              buffer_empty;
      logic [CHAR_W-1:0] char_code;
   } key_char_type;

   logic clock;
   logic reset;

   s2a_req_if req_bus ();
   s2a_rsp_if rsp_bus ();

   scancode_to_ascii_fifo #(.BUF_DEPTH(RING_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic [CHAR_W-1:0] plain_map [128];
   logic [CHAR_W-1:0] shift_map [128];

   logic              shift_down = 1'b0;
   logic              caps_lock  = 1'b0;
   logic [CHAR_W-1:0] ring_model [RING_DEPTH];
   int                head_idx   = 0;
   int                tail_idx   = 0;
   int                held_chars = 0;

   key_char_type pending_chars [$];
   int        error_count  = 0;
   int        items_sent   = 0;
   bit        pacing_on    = 1'b0;
   int        hold_request = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic load_key_maps();
      byte unsigned lower [59];
      byte unsigned upper [59];
      lower = '{8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
                8'd8, 8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
                8'd10, 8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'd96,
                8'd0, 8'd92, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0, "*",
                8'd0, " ", 8'd0};
      upper = '{8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
                8'd8, 8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
                8'd10, 8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, "~",
                8'd0, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0, "*",
                8'd0, " ", 8'd0};
      for (int i = 0; i < 128; i++) begin
         plain_map[i] = (i < 59) ? lower[i][CHAR_W-1:0] : '0;
         shift_map[i] = (i < 59) ? upper[i][CHAR_W-1:0] : '0;
      end
      plain_map[72] = 7'd15;
      plain_map[74] = 7'd45;
      plain_map[75] = 7'd13;
      plain_map[77] = 7'd12;
      plain_map[78] = 7'd43;
      plain_map[80] = 7'd14;
      plain_map[81] = 7'd14;
      foreach (shift_map[i]) begin
         if (i >= 59) begin
            shift_map[i] = plain_map[i];
         end
      end
   endtask

   task automatic apply_keyboard_request(input logic cmd, input logic [SCAN_W-1:0] code);
      logic [CHAR_W-1:0] base;
      logic              use_shift;
      key_char_type      result;
      if (cmd == CMD_READ) begin
         if (held_chars == 0) begin
            result.buffer_empty = 1'b1;
            result.char_code    = '0;
         end else begin
            result.buffer_empty = 1'b0;
            result.char_code    = ring_model[tail_idx];
            tail_idx            = (tail_idx + 1) % RING_DEPTH;
            held_chars--;
         end
         pending_chars.push_back(result);
      end else if (code[SCAN_W-1]) begin
         if (code == KEY_LSHIFT_BRK || code == KEY_RSHIFT_BRK) begin
            shift_down = 1'b0;
         end
      end else if (code == KEY_CAPS) begin
         caps_lock = !caps_lock;
      end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
         shift_down = 1'b1;
      end else if (code != KEY_CTRL && code != KEY_ALT) begin
         base      = plain_map[code[6:0]];
         use_shift = (base >= "a" && base <= "z") ? (shift_down ^ caps_lock) : shift_down;
         ring_model[head_idx] = use_shift ? shift_map[code[6:0]] : base;
         head_idx = (head_idx + 1) % RING_DEPTH;
         if (held_chars < RING_DEPTH) begin
            held_chars++;
         end else begin
            tail_idx = (tail_idx + 1) % RING_DEPTH;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         apply_keyboard_request(req_bus.cmd, req_bus.scan_code);
      end
   end

   always @(posedge clock) begin : response_check
      key_char_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("response error: unexpected transfer empty=%0b char=%h",
                        rsp_bus.buffer_empty, rsp_bus.char_code);
            end
         end else begin
            want = pending_chars.pop_front();
            if (rsp_bus.buffer_empty !== want.buffer_empty ||
                rsp_bus.char_code !== want.char_code) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("response error: expected empty=%0b char=%h, got empty=%0b char=%h",
                           want.buffer_empty, want.char_code,
                           rsp_bus.buffer_empty, rsp_bus.char_code);
               end
            end
         end
      end
   end

   initial begin : response_pacing
      int hold;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (pacing_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("scancode_to_ascii_fifo: mismatch");
      $finish;
   end

   task automatic send_request(input logic cmd, input logic [SCAN_W-1:0] code);
      if (pacing_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.scan_code <= code;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_modifier_keys();
      send_request(CMD_READ, 8'hFF);
      send_request(CMD_SCAN, 8'd30);
      send_request(CMD_SCAN, KEY_LSHIFT);
      send_request(CMD_SCAN, 8'd30);
      send_request(CMD_SCAN, KEY_LSHIFT_BRK);
      send_request(CMD_SCAN, KEY_RSHIFT);
      send_request(CMD_SCAN, 8'd2);
      send_request(CMD_SCAN, KEY_RSHIFT_BRK);
      send_request(CMD_SCAN, KEY_CAPS);
      send_request(CMD_SCAN, 8'd30);
      send_request(CMD_SCAN, 8'd2);
      send_request(CMD_SCAN, KEY_LSHIFT);
      send_request(CMD_SCAN, 8'd30);
      send_request(CMD_SCAN, KEY_LSHIFT_BRK);
      send_request(CMD_SCAN, KEY_CAPS);
      send_request(CMD_SCAN, KEY_CTRL);
      send_request(CMD_SCAN, KEY_ALT);
      send_request(CMD_SCAN, KEY_CTRL | BREAK_BIT);
      send_request(CMD_SCAN, KEY_ALT | BREAK_BIT);
      send_request(CMD_SCAN, 8'hFF);
      send_request(CMD_SCAN, 8'h00);
      send_request(CMD_SCAN, 8'h7F);
      repeat (8) send_request(CMD_READ, 8'h00);
      wait_for_drain();
   endtask

   task automatic test_typing(input int item_count);
      int                start;
      int                keys;
      int                reads;
      int                pick;
      logic [SCAN_W-1:0] key;
      start = items_sent;
      while (items_sent - start < item_count) begin
         keys  = $urandom_range(1, 24);
         reads = $urandom_range(0, 20);
         repeat (keys) begin
            pick = $urandom_range(0, 99);
            key  = SCAN_W'($urandom_range(0, 127));
            if (pick < 10) begin
               send_request(CMD_SCAN, SCAN_W'($urandom_range(0, 255)));
            end else if (pick < 15) begin
               send_request(CMD_SCAN, KEY_CAPS);
               send_request(CMD_SCAN, KEY_CAPS | BREAK_BIT);
            end else if (pick < 30) begin
               send_request(CMD_SCAN, $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT);
               send_request(CMD_SCAN, key);
               send_request(CMD_SCAN, key | BREAK_BIT);
               send_request(CMD_SCAN, $urandom_range(0, 1) ? KEY_LSHIFT_BRK : KEY_RSHIFT_BRK);
            end else if (pick < 35) begin
               send_request(CMD_SCAN, $urandom_range(0, 1) ? KEY_LSHIFT : KEY_LSHIFT_BRK);
            end else begin
               send_request(CMD_SCAN, key);
               if ($urandom_range(0, 1)) begin
                  send_request(CMD_SCAN, key | BREAK_BIT);
               end
            end
         end
         repeat (reads) send_request(CMD_READ, SCAN_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_backpressure();
      hold_request = LONG_HOLD;
      repeat (10) send_request(CMD_SCAN, SCAN_W'($urandom_range(0, 127)));
      repeat (20) send_request(CMD_READ, SCAN_W'($urandom_range(0, 255)));
      repeat (10) send_request(CMD_SCAN, SCAN_W'($urandom_range(0, 127)));
      repeat (10) send_request(CMD_READ, SCAN_W'($urandom_range(0, 255)));
      wait_for_drain();
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_SCAN;
      req_bus.scan_code <= '0;
      load_key_maps();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      pacing_on = 1'b1;
      test_modifier_keys();
      test_typing(900);
      test_backpressure();
      pacing_on = 1'b0;
      test_typing(250);
      wait_for_drain();
      if (error_count == 0) begin
         $display("scancode_to_ascii_fifo: match");
      end else begin
         $display("scancode_to_ascii_fifo: mismatch");
      end
      $finish;
   end

endmodule
